// File: hw/rtl/erm_pkg.sv
// ----------------------------------------------------------------------------
// erm_pkg
// Shared types, constants and helper functions of the Euler rotation matrix.
// ----------------------------------------------------------------------------
package erm_pkg;

  localparam int ANGLE_FRAC_BITS = 8;
  localparam int OUT_FRAC_BITS   = 14;
  localparam int TRIG_ITERATIONS = 16;

  localparam int IN_W   = 20;
  localparam int OUT_W  = 16;
  localparam int WB     = 30;
  localparam int TRIG_W = 32;   // clamped sine and cosine, Q30
  localparam int XW     = 34;   // CORDIC x and y
  localparam int ZW     = 34;   // CORDIC residual angle

  localparam longint CORDIC_GAIN = 652032874;

  // Angle reduction and conversion to a binary angle.
  localparam longint ANG_D   = longint'(360) << ANGLE_FRAC_BITS;
  localparam int     R_W     = $clog2(ANG_D);
  localparam longint Q0      = (longint'(1) << 32) / ANG_D;
  localparam longint R0      = (longint'(1) << 32) % ANG_D;
  localparam longint M_MAX   = (ANG_D - 1) * R0 + ANG_D / 2;
  localparam int     M_W     = $clog2(M_MAX + 1);
  localparam longint RECIP   = (longint'(1) << M_W) / ANG_D;
  localparam int     RC_W    = $clog2(RECIP + 1);
  localparam int     QE_W    = R_W + 1;
  localparam longint OFF_K   = ((longint'(1) << (IN_W - 1)) + ANG_D - 1) / ANG_D;
  localparam longint U_MAX   = (longint'(1) << (IN_W - 1)) - 1 + OFF_K * ANG_D;
  localparam int     U_W     = $clog2(U_MAX + 1);
  localparam int     NSUB    = $clog2(U_MAX / ANG_D + 1);

  localparam int LANE_LAT  = TRIG_ITERATIONS + 5;
  localparam int MERGE_LAT = 3;
  localparam int PIPE_LAT  = LANE_LAT + MERGE_LAT;

  localparam int     OUT_SH  = WB - OUT_FRAC_BITS;
  localparam longint OUT_RND = (OUT_SH > 0) ? (longint'(1) << (OUT_SH - 1)) : 0;
  localparam longint OUT_LIM = longint'(1) << OUT_FRAC_BITS;

  typedef struct packed {
    logic signed [IN_W-1:0] angle_x;
    logic signed [IN_W-1:0] angle_y;
    logic signed [IN_W-1:0] angle_z;
  } angles_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] m_c0_r0;
    logic signed [OUT_W-1:0] m_c0_r1;
    logic signed [OUT_W-1:0] m_c0_r2;
    logic signed [OUT_W-1:0] m_c1_r0;
    logic signed [OUT_W-1:0] m_c1_r1;
    logic signed [OUT_W-1:0] m_c1_r2;
    logic signed [OUT_W-1:0] m_c2_r0;
    logic signed [OUT_W-1:0] m_c2_r1;
    logic signed [OUT_W-1:0] m_c2_r2;
  } matrix_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
  } trig_t;

  typedef struct packed {
    logic en;
  } pipe_ctl_t;

  // atan(2^-i) as a fraction of a turn, scaled by 2^32.
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] v;
    unique case (i)
      0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
      3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
      6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
      9: v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
      12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
      15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
      18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
      21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
      24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
      27: v = 32'h00000005; 28: v = 32'h00000003; 29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // Q30 product with round half up.
  function automatic logic signed [TRIG_W-1:0] mulq(input logic signed [TRIG_W-1:0] a,
                                                     input logic signed [TRIG_W-1:0] b);
    logic signed [2*TRIG_W-1:0] p;
    p = a * b;
    p = (p + (64'sd1 <<< (WB - 1))) >>> WB;
    return p[TRIG_W-1:0];
  endfunction

  // Q30 to output format: round, saturate, keep the low bits.
  function automatic logic [OUT_W-1:0] to_out(input logic signed [TRIG_W:0] v);
    logic signed [63:0] w;
    w = (64'(v) + OUT_RND) >>> OUT_SH;
    if (w > OUT_LIM) begin
      w = OUT_LIM;
    end else if (w < -OUT_LIM) begin
      w = -OUT_LIM;
    end
    return w[OUT_W-1:0];
  endfunction

endpackage

// File: hw/rtl/erm_lane.sv
// ----------------------------------------------------------------------------
// erm_lane
// One angle lane: reduce modulo 360, convert to a binary angle, fold into
// the right half plane and run a pipelined CORDIC for sine and cosine.
// ----------------------------------------------------------------------------
module erm_lane
  import erm_pkg::*;
(
  input  logic                   clk,
  input  pipe_ctl_t              ctl,
  input  logic signed [IN_W-1:0] angle,
  output trig_t                  trig
);

  logic [U_W-1:0]       u;
  logic [R_W-1:0]       r_r, r_nxt;
  logic [31:0]          a_r, a2_r;
  logic [M_W-1:0]       m_r, m2_r;
  logic [QE_W-1:0]      qe_r;
  logic [M_W+RC_W-1:0]  prod;
  logic [M_W+1:0]       qd;
  logic [31:0]          t;
  logic [31:0]          tf;
  logic                 fold;
  logic signed [ZW-1:0] z0_r;
  logic                 neg_r;
  logic                 neg_d_r [TRIG_ITERATIONS];
  logic signed [XW-1:0] x_r [TRIG_ITERATIONS+1];
  logic signed [XW-1:0] y_r [TRIG_ITERATIONS+1];
  logic signed [ZW-1:0] z_r [TRIG_ITERATIONS+1];
  logic signed [XW-1:0] xf, yf;
  trig_t                trig_r, trig_nxt;

  // Bring the angle into [0, 360) by a few conditional subtractions.
  always_comb begin
    u = U_W'(longint'(angle) + OFF_K * ANG_D);
    for (int j = NSUB - 1; j >= 0; j--) begin
      if (u >= U_W'(ANG_D << j)) begin
        u = u - U_W'(ANG_D << j);
      end
    end
    r_nxt = u[R_W-1:0];
  end

  assign prod = m_r * RC_W'(RECIP);
  assign qd   = (M_W+2)'(qe_r) * (M_W+2)'(ANG_D);

  // The reciprocal estimate is at most one short of the true quotient.
  always_comb begin
    t = a2_r + ((M_W+2)'(m2_r) >= qd + (M_W+2)'(ANG_D) ? 32'(qe_r) + 32'd1 : 32'(qe_r));
    fold = t[31] ^ t[30];
    tf = fold ? {~t[31], t[30:0]} : t;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      r_r   <= r_nxt;
      a_r   <= 32'(longint'(r_r) * Q0);
      m_r   <= M_W'(longint'(r_r) * R0 + ANG_D / 2);
      a2_r  <= a_r;
      m2_r  <= m_r;
      qe_r  <= QE_W'(prod >> M_W);
      z0_r  <= ZW'($signed(tf));
      neg_r <= fold;
    end
  end

  assign x_r[0] = XW'(CORDIC_GAIN);
  assign y_r[0] = '0;
  assign z_r[0] = z0_r;

  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_step
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] at;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    assign at = ZW'(atan_turn(i));
    always_ff @(posedge clk) begin
      if (ctl.en) begin
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - at;
        end else begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + at;
        end
        neg_d_r[i] <= (i == 0) ? neg_r : neg_d_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  always_comb begin
    xf = neg_d_r[TRIG_ITERATIONS-1] ? -x_r[TRIG_ITERATIONS] : x_r[TRIG_ITERATIONS];
    yf = neg_d_r[TRIG_ITERATIONS-1] ? -y_r[TRIG_ITERATIONS] : y_r[TRIG_ITERATIONS];
    if (yf > XW'(longint'(1) << WB)) begin
      trig_nxt.s = TRIG_W'(longint'(1) << WB);
    end else if (yf < -XW'(longint'(1) << WB)) begin
      trig_nxt.s = -TRIG_W'(longint'(1) << WB);
    end else begin
      trig_nxt.s = yf[TRIG_W-1:0];
    end
    if (xf > XW'(longint'(1) << WB)) begin
      trig_nxt.c = TRIG_W'(longint'(1) << WB);
    end else if (xf < -XW'(longint'(1) << WB)) begin
      trig_nxt.c = -TRIG_W'(longint'(1) << WB);
    end else begin
      trig_nxt.c = xf[TRIG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      trig_r <= trig_nxt;
    end
  end

  assign trig = trig_r;

endmodule

// File: hw/rtl/erm_merge.sv
// ----------------------------------------------------------------------------
// erm_merge
// Combines the three lanes' sines and cosines into the nine matrix entries
// over three registered product and sum stages.
// ----------------------------------------------------------------------------
module erm_merge
  import erm_pkg::*;
(
  input  logic      clk,
  input  pipe_ctl_t ctl,
  input  trig_t     tx,
  input  trig_t     ty,
  input  trig_t     tz,
  output matrix_t   mat
);

  logic signed [TRIG_W-1:0] sxsy_r, cxsy_r, cycz_r, cysz_r, sxcy_r, cxcy_r;
  logic signed [TRIG_W-1:0] cxsz_r, sxsz_r, cxcz_r, sxcz_r, sz_r, cz_r, sy_r;
  logic signed [TRIG_W-1:0] q1_r, q2_r, q4_r, q5_r;
  logic signed [TRIG_W-1:0] cycz2_r, cysz2_r, sxcy2_r, cxcy2_r;
  logic signed [TRIG_W-1:0] cxsz2_r, sxsz2_r, cxcz2_r, sxcz2_r, sy2_r;
  matrix_t                  mat_r;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      sxsy_r <= mulq(tx.s, ty.s);
      cxsy_r <= mulq(tx.c, ty.s);
      cycz_r <= mulq(ty.c, tz.c);
      cysz_r <= mulq(ty.c, tz.s);
      sxcy_r <= mulq(tx.s, ty.c);
      cxcy_r <= mulq(tx.c, ty.c);
      cxsz_r <= mulq(tx.c, tz.s);
      sxsz_r <= mulq(tx.s, tz.s);
      cxcz_r <= mulq(tx.c, tz.c);
      sxcz_r <= mulq(tx.s, tz.c);
      sz_r   <= tz.s;
      cz_r   <= tz.c;
      sy_r   <= ty.s;

      q1_r    <= mulq(sxsy_r, cz_r);
      q2_r    <= mulq(cxsy_r, cz_r);
      q4_r    <= mulq(sxsy_r, sz_r);
      q5_r    <= mulq(cxsy_r, sz_r);
      cycz2_r <= cycz_r;
      cysz2_r <= cysz_r;
      sxcy2_r <= sxcy_r;
      cxcy2_r <= cxcy_r;
      cxsz2_r <= cxsz_r;
      sxsz2_r <= sxsz_r;
      cxcz2_r <= cxcz_r;
      sxcz2_r <= sxcz_r;
      sy2_r   <= sy_r;

      mat_r.m_c0_r0 <= to_out((TRIG_W+1)'(cycz2_r));
      mat_r.m_c0_r1 <= to_out((TRIG_W+1)'(q1_r) - (TRIG_W+1)'(cxsz2_r));
      mat_r.m_c0_r2 <= to_out((TRIG_W+1)'(q2_r) + (TRIG_W+1)'(sxsz2_r));
      mat_r.m_c1_r0 <= to_out((TRIG_W+1)'(cysz2_r));
      mat_r.m_c1_r1 <= to_out((TRIG_W+1)'(q4_r) + (TRIG_W+1)'(cxcz2_r));
      mat_r.m_c1_r2 <= to_out((TRIG_W+1)'(q5_r) - (TRIG_W+1)'(sxcz2_r));
      mat_r.m_c2_r0 <= to_out(-(TRIG_W+1)'(sy2_r));
      mat_r.m_c2_r1 <= to_out((TRIG_W+1)'(sxcy2_r));
      mat_r.m_c2_r2 <= to_out((TRIG_W+1)'(cxcy2_r));
    end
  end

  assign mat = mat_r;

endmodule

// File: hw/rtl/euler_rotation_matrix.sv
// ----------------------------------------------------------------------------
// euler_rotation_matrix
// X-Y-Z Euler angles to the 3x3 rotation matrix, one item per cycle unless a result is stalled.
// ----------------------------------------------------------------------------
//   channel | direction | payload   | handshake
//   in_     | input     | angles_t  | in_valid / in_stall
//   out_    | output    | matrix_t  | out_valid / out_stall
//
// One beat is accepted per cycle while no valid result is stalled; its result
// passes through the angle conversion and CORDIC chain of each lane and then
// the three product and sum stages of the merge.
// Reset clears only the valid bits of the pipeline.
// A stall of a valid result freezes the whole pipeline and stalls the input.
// ----------------------------------------------------------------------------
module euler_rotation_matrix
  import erm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  angles_t in_data,
  output logic    out_valid,
  input  logic    out_stall,
  output matrix_t out_data
);

  logic      vld_r [PIPE_LAT];
  logic      adv;
  pipe_ctl_t ctl;
  trig_t     tx, ty, tz;

  assign adv      = !(vld_r[PIPE_LAT-1] && out_stall);
  assign ctl.en   = adv;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < PIPE_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  erm_lane u_lane_x (.clk(clk), .ctl(ctl), .angle(in_data.angle_x), .trig(tx));
  erm_lane u_lane_y (.clk(clk), .ctl(ctl), .angle(in_data.angle_y), .trig(ty));
  erm_lane u_lane_z (.clk(clk), .ctl(ctl), .angle(in_data.angle_z), .trig(tz));

  erm_merge u_merge (.clk(clk), .ctl(ctl), .tx(tx), .ty(ty), .tz(tz), .mat(out_data));

  assign out_valid = vld_r[PIPE_LAT-1];

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted beat did not enter the pipeline");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !vld_r[PIPE_LAT-2]) |=> !out_valid)
    else $error("delivered beat repeated");

endmodule

// File: tb/euler_rotation_matrix_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// euler_rotation_matrix_tb
// Checks the rotation matrix block against a bit-exact CORDIC matrix predictor
// under random input gaps and output stalls, with directed and random angles.
// ----------------------------------------------------------------------------

class matrix_scoreboard;
  erm_pkg::matrix_t pending_q[$];
  int errors;
  int checked;

  function new();
    errors = 0;
    checked = 0;
  endfunction

  static function longint lim(longint v, longint l);
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

  static function longint qmul(longint a, longint b);
    return (a * b + (longint'(1) << 29)) >>> 30;
  endfunction

  static function logic [15:0] q14(longint v);
    longint w;
    w = (v + (longint'(1) << (29 - erm_pkg::OUT_FRAC_BITS))) >>> (30 - erm_pkg::OUT_FRAC_BITS);
    w = lim(w, longint'(1) << erm_pkg::OUT_FRAC_BITS);
    return w[15:0];
  endfunction

  static function void sincos(logic signed [19:0] ang, output longint s, output longint c);
    longint a, d, r, z, x, y, xs, ys;
    longint unsigned t;
    logic [31:0] tbl[32];
    bit flip;
    tbl = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
            32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
            32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
            32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
    a = ang;
    d = longint'(360) << erm_pkg::ANGLE_FRAC_BITS;
    r = a % d;
    if (r < 0) r += d;
    t = ((longint'(r) << 32) + d / 2) / d;
    t = t & 64'hFFFF_FFFF;
    flip = 0;
    if (t[31:30] == 2'b01 || t[31:30] == 2'b10) begin
      t = (t - 64'h8000_0000) & 64'hFFFF_FFFF;
      flip = 1;
    end
    z = t[31] ? longint'(t) - (longint'(1) << 32) : longint'(t);
    x = erm_pkg::CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < erm_pkg::TRIG_ITERATIONS && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(tbl[i]);
      end else begin
        x += ys; y -= xs; z += longint'(tbl[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = lim(y, longint'(1) << 30);
    c = lim(x, longint'(1) << 30);
  endfunction

  function void note_angles(erm_pkg::angles_t a);
    longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
    erm_pkg::matrix_t m;
    sincos(a.angle_x, sx, cx);
    sincos(a.angle_y, sy, cy);
    sincos(a.angle_z, sz, cz);
    sxsy = qmul(sx, sy);
    cxsy = qmul(cx, sy);
    m.m_c0_r0 = q14(qmul(cy, cz));
    m.m_c0_r1 = q14(qmul(sxsy, cz) - qmul(cx, sz));
    m.m_c0_r2 = q14(qmul(cxsy, cz) + qmul(sx, sz));
    m.m_c1_r0 = q14(qmul(cy, sz));
    m.m_c1_r1 = q14(qmul(sxsy, sz) + qmul(cx, cz));
    m.m_c1_r2 = q14(qmul(cxsy, sz) - qmul(sx, cz));
    m.m_c2_r0 = q14(-sy);
    m.m_c2_r1 = q14(qmul(sx, cy));
    m.m_c2_r2 = q14(qmul(cx, cy));
    pending_q.push_back(m);
  endfunction

  function void check_matrix(erm_pkg::matrix_t got);
    erm_pkg::matrix_t exp_m;
    logic [15:0] e[9], g[9];
    checked++;
    if (pending_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result beat %h", $time, got);
      return;
    end
    exp_m = pending_q.pop_front();
    e = '{exp_m.m_c0_r0, exp_m.m_c0_r1, exp_m.m_c0_r2, exp_m.m_c1_r0, exp_m.m_c1_r1,
          exp_m.m_c1_r2, exp_m.m_c2_r0, exp_m.m_c2_r1, exp_m.m_c2_r2};
    g = '{got.m_c0_r0, got.m_c0_r1, got.m_c0_r2, got.m_c1_r0, got.m_c1_r1,
          got.m_c1_r2, got.m_c2_r0, got.m_c2_r1, got.m_c2_r2};
    foreach (e[k]) begin
      if (e[k] !== g[k]) begin
        errors++;
        $display("%0t: entry c%0d_r%0d expected %0d actual %0d", $time, k / 3, k % 3,
                 $signed(e[k]), $signed(g[k]));
      end
    end
  endfunction
endclass

module euler_rotation_matrix_tb;
  import erm_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  angles_t in_data = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  matrix_t out_data;

  matrix_scoreboard sb = new();
  int idle_cycles = 0;
  int sent = 0;
  bit sending_done = 0;

  euler_rotation_matrix dut (.*);

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Both sides: accepted beats go to the scoreboard at the edge they are taken, delivered results are checked.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_angles(in_data);
      sent++;
    end
    if (rst_n && out_valid && !out_stall) sb.check_matrix(out_data);
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // Receiver stall pattern: bursts of stall, some long, some stretches clear.
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      n = pick_gap();
      repeat (n) @(posedge clk) out_stall <= 1'b1;
      n = $urandom_range(1, 30);
      repeat (n) @(posedge clk) out_stall <= 1'b0;
    end
  end

  task automatic send_angles(logic signed [19:0] ax, logic signed [19:0] ay,
                             logic signed [19:0] az, bit hold);
    int g;
    in_valid <= 1'b1;
    in_data <= '{angle_x: ax, angle_y: ay, angle_z: az};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    g = hold ? 0 : pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic signed [19:0] rnd_angle();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 20'($urandom);
    if (r < 8) return 20'(int'($urandom_range(0, 360 * 4)) * 64 - 46080);
    return 20'(int'($urandom_range(0, 16)) * 5760 + $urandom_range(0, 2) - 1);
  endfunction

  initial begin
    logic signed [19:0] dirs[12];
    bit hold;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Extremes, quarter turns, near-fold points and wrapped angles.
    dirs = '{20'sd0, 20'sh7FFFF, 20'sh80000, 20'sd23040, -20'sd23040, 20'sd46080,
             20'sd92160, 20'sd69120, 20'sd23039, 20'sd23041, -20'sd1, 20'sd1};
    foreach (dirs[i]) send_angles(dirs[i], dirs[(i + 3) % 12], dirs[(i + 7) % 12], 0);
    send_angles(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 0);
    send_angles(20'sh80000, 20'sh80000, 20'sh80000, 0);
    send_angles(20'sd0, 20'sd23040, 20'sd0, 0);
    send_angles(20'sd0, -20'sd23040, 20'sd0, 0);
    send_angles(20'sh55555, 20'shAAAAA, 20'sh0F0F0, 0);
    for (int i = 0; i < 1650; i++) begin
      hold = (i % 200) < 60;  // unbroken streams now and then
      send_angles(rnd_angle(), rnd_angle(), rnd_angle(), hold);
    end
    in_valid <= 1'b0;
    sending_done = 1;
  end

  initial begin
    wait (sending_done);
    while (sb.pending_q.size() != 0 && idle_cycles < IDLE_LIMIT) @(posedge clk);
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    repeat (PIPE_LAT + 10) @(posedge clk);
    $display("Covered %0d angle triples and %0d matrix beats with random gaps and stalls.",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Watchdog expired with %0d results outstanding.", sb.pending_q.size());
    $display("TEST FAILED");
    $finish;
  end
endmodule
